### hdl/bed_pkg.sv
// Shared constants, types and codes for the binary erosion / dilation block.
// Depends on nothing; used by bed_line_ram and binary_erosion_dilation.
`default_nettype none

package bed_pkg;

   // Sizing of the line store and of the window.
   localparam int MAX_WIN    = 9;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W     = 8;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int SLOT_W    = $clog2(MAX_WIN);
   localparam int ROW_W     = $clog2(MAX_HEIGHT + MAX_WIN);
   localparam int OROW_W    = $clog2(MAX_HEIGHT);
   localparam int FW_W      = 11;
   localparam int FH_W      = 13;
   localparam int WIN_W     = 4;
   localparam int REACH_W   = $clog2(MAX_WIN / 2 + 1);
   localparam int LAG_W     = $clog2((MAX_WIN / 2) * MAX_WIDTH + MAX_WIN / 2 + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [PIX_W-1:0] PIX_ONES = 8'hFF;
   localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

   // Result queue.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_WIN_WIDTH    = 3'd2,
      CSR_WIN_HEIGHT   = 3'd3,
      CSR_OP_SELECT    = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_ERODE  = 1'b0,
      OP_DILATE = 1'b1
   } op_type;

   // One line-store word holds the same column of every ring slot.
   typedef logic [MAX_WIN-1:0][PIX_W-1:0] line_word_type;

   typedef struct packed {
      logic              en;
      logic [COL_W-1:0]  addr;
      logic [SLOT_W-1:0] lane;
      logic [PIX_W-1:0]  data;
   } ram_wr_type;

   typedef struct packed {
      logic             ero;
      logic             dil;
      logic [PIX_W-1:0] px;
   } win_entry_type;

   typedef struct packed {
      logic [PIX_W-1:0] px;
      logic             last;
   } rsp_entry_type;

   // Reach of a window size: clamp to 1..MAX_WIN, then (size-1)/2.
   function automatic logic [REACH_W-1:0] reach_of(input logic [WIN_W-1:0] win);
      logic [WIN_W-1:0] c;
      begin
         if (win == '0) begin
            c = WIN_W'(1);
         end else if (win > WIN_W'(MAX_WIN)) begin
            c = WIN_W'(MAX_WIN);
         end else begin
            c = win;
         end
         reach_of = REACH_W'((c - WIN_W'(1)) >> 1);
      end
   endfunction

endpackage

`default_nettype wire

### hdl/binary_erosion_dilation.sv
// Top level of the binary erosion / dilation block for raster pixel streams.
// Depends on bed_pkg and bed_line_ram.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | req_valid req_ready req_mode req_pixel  | in
//   result  | rsp_valid rsp_ready rsp_out_pixel       | out
//           | rsp_frame_last                          |
//   csr     | csr_write_en csr_index csr_wdata        | in
//
// One beat is taken every cycle while req_ready is high; a result passes through
// the line-store read, column reduction and window reduction before it leaves.
// The line-store word read each cycle carries all nine ring rows of one
// column, so the rate is one pixel per clock while req_ready is high.
// Reset clears counters, window and result queue; line-store contents stay.
// A four-entry result queue absorbs stalls; req_ready falls when it could fill.
`default_nettype none

module binary_erosion_dilation (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_mode,
   input  wire logic [bed_pkg::PIX_W-1:0]        req_pixel,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [bed_pkg::PIX_W-1:0]             rsp_out_pixel,
   output logic                                  rsp_frame_last,
   input  wire logic                             csr_write_en,
   input  wire logic [bed_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bed_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int W_CMP = bed_pkg::FW_W + 1;
   localparam int H_CMP = bed_pkg::ROW_W + 1;

   // Configuration registers.
   logic [bed_pkg::FW_W-1:0]  frame_width_ff;
   logic [bed_pkg::FH_W-1:0]  frame_height_ff;
   logic [bed_pkg::WIN_W-1:0] win_width_ff;
   logic [bed_pkg::WIN_W-1:0] win_height_ff;
   bed_pkg::op_type           op_select_ff;
   logic                      csr_hit;

   // Derived frame geometry.
   logic [bed_pkg::FW_W-1:0]    w_eff;
   logic [bed_pkg::FH_W-1:0]    h_eff;
   logic [bed_pkg::REACH_W-1:0] rx;
   logic [bed_pkg::REACH_W-1:0] ry;
   logic                        no_interior;
   logic [bed_pkg::LAG_W-1:0]   lag;

   // Input and output position counters.
   logic [bed_pkg::COL_W-1:0]  in_col_ff,  in_col_in;
   logic [bed_pkg::ROW_W-1:0]  in_row_ff,  in_row_in;
   logic [bed_pkg::SLOT_W-1:0] wslot_ff,   wslot_in;
   logic [bed_pkg::LAG_W-1:0]  wcnt_ff,    wcnt_in;
   logic [bed_pkg::COL_W-1:0]  ocol_ff,    ocol_in;
   logic [bed_pkg::OROW_W-1:0] orow_ff,    orow_in;
   logic [bed_pkg::SLOT_W-1:0] oslot_ff,   oslot_in;

   logic acc, in_done, is_px, is_dr, push, emit, out_last, col_last, ocol_last;
   logic fwd, cx_int, p_int;
   logic [bed_pkg::COL_W-1:0] rd_addr;
   bed_pkg::ram_wr_type       ram_wr;
   bed_pkg::line_word_type    rd_data;

   // Stage one: line-store read in flight.
   logic                       s1_push_ff, s1_emit_ff, s1_last_ff;
   logic                       s1_fwd_ff, s1_cxint_ff, s1_pint_ff;
   logic [bed_pkg::PIX_W-1:0]  s1_px_ff;
   logic [bed_pkg::SLOT_W-1:0] s1_wslot_ff, s1_oslot_ff;
   logic [bed_pkg::ROW_W-1:0]  s1_row_ff;

   // Stage two: window shift line.
   bed_pkg::win_entry_type     win_ff [bed_pkg::MAX_WIN];
   bed_pkg::win_entry_type     col_entry;
   logic [bed_pkg::PIX_W-1:0]  pass_px;
   logic                       s2_emit_ff, s2_last_ff, s2_pint_ff, s2_noint_ff;
   logic [bed_pkg::PIX_W-1:0]  s2_pass_ff;

   // Result queue.
   bed_pkg::rsp_entry_type        fifo_ff [bed_pkg::FIFO_DEPTH];
   bed_pkg::rsp_entry_type        res_entry;
   logic [bed_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [bed_pkg::FIFO_CNT_W-1:0] cnt_ff;
   logic [bed_pkg::FIFO_CNT_W-1:0] pending;
   logic                           fifo_pop;

   // Configuration writes; any known register restarts the frame.
   always_comb begin
      unique case (csr_index)
         bed_pkg::CSR_FRAME_WIDTH,
         bed_pkg::CSR_FRAME_HEIGHT,
         bed_pkg::CSR_WIN_WIDTH,
         bed_pkg::CSR_WIN_HEIGHT,
         bed_pkg::CSR_OP_SELECT: csr_hit = csr_write_en;
         default:                csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bed_pkg::FW_W'(1024);
         frame_height_ff <= bed_pkg::FH_W'(1024);
         win_width_ff    <= bed_pkg::WIN_W'(3);
         win_height_ff   <= bed_pkg::WIN_W'(3);
         op_select_ff    <= bed_pkg::OP_ERODE;
      end else if (csr_write_en) begin
         unique case (csr_index)
            bed_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[bed_pkg::FW_W-1:0];
            bed_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[bed_pkg::FH_W-1:0];
            bed_pkg::CSR_WIN_WIDTH:    win_width_ff    <= csr_wdata[bed_pkg::WIN_W-1:0];
            bed_pkg::CSR_WIN_HEIGHT:   win_height_ff   <= csr_wdata[bed_pkg::WIN_W-1:0];
            bed_pkg::CSR_OP_SELECT:    op_select_ff    <= bed_pkg::op_type'(csr_wdata[0]);
            default: ;
         endcase
      end
   end

   // Clamped geometry, reach and the lag between input and output.
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = bed_pkg::FW_W'(1);
      end else if (frame_width_ff > bed_pkg::FW_W'(bed_pkg::MAX_WIDTH)) begin
         w_eff = bed_pkg::FW_W'(bed_pkg::MAX_WIDTH);
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_eff = bed_pkg::FH_W'(1);
      end else if (frame_height_ff > bed_pkg::FH_W'(bed_pkg::MAX_HEIGHT)) begin
         h_eff = bed_pkg::FH_W'(bed_pkg::MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end
      rx  = bed_pkg::reach_of(win_width_ff);
      ry  = bed_pkg::reach_of(win_height_ff);
      no_interior = (W_CMP'(w_eff) < W_CMP'({rx, 1'b1}))
                 || (H_CMP'(h_eff) < H_CMP'({ry, 1'b1}));
      lag = bed_pkg::LAG_W'(bed_pkg::LAG_W'(ry) * bed_pkg::LAG_W'(w_eff))
          + bed_pkg::LAG_W'(rx);
   end

   // Beat classification and result generation.
   always_comb begin
      acc       = req_valid && req_ready;
      in_done   = in_row_ff >= bed_pkg::ROW_W'(h_eff);
      is_px     = acc && !req_mode && !in_done;
      is_dr     = acc && req_mode && in_done;
      push      = is_px || is_dr;
      emit      = is_dr || (is_px && (wcnt_ff == lag));
      col_last  = W_CMP'(in_col_ff) == W_CMP'(w_eff) - W_CMP'(1);
      ocol_last = W_CMP'(ocol_ff) == W_CMP'(w_eff) - W_CMP'(1);
      out_last  = ocol_last && (H_CMP'(orow_ff) == H_CMP'(h_eff) - H_CMP'(1));
      cx_int    = (W_CMP'(in_col_ff) >= W_CMP'(rx))
               && (W_CMP'(in_col_ff) + W_CMP'(rx) <= W_CMP'(w_eff) - W_CMP'(1));
      p_int     = (W_CMP'(ocol_ff) >= W_CMP'(rx))
               && (W_CMP'(ocol_ff) + W_CMP'(rx) <= W_CMP'(w_eff) - W_CMP'(1))
               && (H_CMP'(orow_ff) >= H_CMP'(ry))
               && (H_CMP'(orow_ff) + H_CMP'(ry) <= H_CMP'(h_eff) - H_CMP'(1));
   end

   // Counter updates: input position runs on past the frame while draining.
   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      wslot_in  = wslot_ff;
      wcnt_in   = wcnt_ff;
      ocol_in   = ocol_ff;
      orow_in   = orow_ff;
      oslot_in  = oslot_ff;
      if (csr_hit || (emit && out_last)) begin
         in_col_in = '0;
         in_row_in = '0;
         wslot_in  = '0;
         wcnt_in   = '0;
         ocol_in   = '0;
         orow_in   = '0;
         oslot_in  = '0;
      end else begin
         if (push) begin
            if (col_last) begin
               in_col_in = '0;
               in_row_in = in_row_ff + bed_pkg::ROW_W'(1);
               wslot_in  = (wslot_ff == bed_pkg::SLOT_W'(bed_pkg::MAX_WIN - 1))
                         ? '0 : wslot_ff + bed_pkg::SLOT_W'(1);
            end else begin
               in_col_in = in_col_ff + bed_pkg::COL_W'(1);
            end
         end
         if (is_px && (wcnt_ff != lag)) begin
            wcnt_in = wcnt_ff + bed_pkg::LAG_W'(1);
         end
         if (emit) begin
            if (ocol_last) begin
               ocol_in  = '0;
               orow_in  = orow_ff + bed_pkg::OROW_W'(1);
               oslot_in = (oslot_ff == bed_pkg::SLOT_W'(bed_pkg::MAX_WIN - 1))
                        ? '0 : oslot_ff + bed_pkg::SLOT_W'(1);
            end else begin
               ocol_in = ocol_ff + bed_pkg::COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         wslot_ff  <= '0;
         wcnt_ff   <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
         oslot_ff  <= '0;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         wslot_ff  <= wslot_in;
         wcnt_ff   <= wcnt_in;
         ocol_ff   <= ocol_in;
         orow_ff   <= orow_in;
         oslot_ff  <= oslot_in;
      end
   end

   // Line store: write the new pixel, read the column of the newest window
   // column, or the output pixel itself when no pixel of the frame is interior.
   always_comb begin
      rd_addr     = no_interior ? ocol_ff : in_col_ff;
      ram_wr.en   = is_px;
      ram_wr.addr = in_col_ff;
      ram_wr.lane = wslot_ff;
      ram_wr.data = req_pixel;
      fwd         = is_px && (rd_addr == in_col_ff);
   end

   bed_line_ram u_line_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_push_ff <= 1'b0;
         s1_emit_ff <= 1'b0;
         s1_last_ff <= 1'b0;
      end else begin
         s1_push_ff <= push;
         s1_emit_ff <= emit;
         s1_last_ff <= emit && out_last;
      end
   end

   always_ff @(posedge clock) begin
      s1_fwd_ff   <= fwd;
      s1_px_ff    <= req_pixel;
      s1_wslot_ff <= wslot_ff;
      s1_oslot_ff <= oslot_ff;
      s1_row_ff   <= in_row_ff;
      s1_cxint_ff <= cx_int;
      s1_pint_ff  <= p_int;
   end

   // Column reduction over the rows of the window around the newest column.
   always_comb begin
      bed_pkg::line_word_type    lanes;
      logic [bed_pkg::SLOT_W:0]  t;
      logic [bed_pkg::SLOT_W:0]  cs;
      logic [H_CMP-1:0]          r;
      logic                      y_int;
      logic                      ero;
      logic                      dil;
      lanes = rd_data;
      if (s1_fwd_ff) begin
         lanes[s1_wslot_ff] = s1_px_ff;
      end
      ero = 1'b1;
      dil = 1'b0;
      for (int k = 0; k < bed_pkg::MAX_WIN; k++) begin
         t = (bed_pkg::SLOT_W + 1)'(s1_wslot_ff) + (bed_pkg::SLOT_W + 1)'(bed_pkg::MAX_WIN)
           - (bed_pkg::SLOT_W + 1)'(k);
         if (t >= (bed_pkg::SLOT_W + 1)'(bed_pkg::MAX_WIN)) begin
            t = t - (bed_pkg::SLOT_W + 1)'(bed_pkg::MAX_WIN);
         end
         r = H_CMP'(s1_row_ff) - H_CMP'(k);
         y_int = (H_CMP'(s1_row_ff) >= H_CMP'(k))
              && (r >= H_CMP'(ry))
              && (r + H_CMP'(ry) <= H_CMP'(h_eff) - H_CMP'(1));
         if ((bed_pkg::REACH_W + 1)'(k) <= {ry, 1'b0}) begin
            if (lanes[t[bed_pkg::SLOT_W-1:0]] != bed_pkg::PIX_ONES) begin
               ero = 1'b0;
            end
            if (y_int && (lanes[t[bed_pkg::SLOT_W-1:0]] == bed_pkg::PIX_ONES)) begin
               dil = 1'b1;
            end
         end
      end
      cs = (bed_pkg::SLOT_W + 1)'(s1_wslot_ff) + (bed_pkg::SLOT_W + 1)'(bed_pkg::MAX_WIN)
         - (bed_pkg::SLOT_W + 1)'(ry);
      if (cs >= (bed_pkg::SLOT_W + 1)'(bed_pkg::MAX_WIN)) begin
         cs = cs - (bed_pkg::SLOT_W + 1)'(bed_pkg::MAX_WIN);
      end
      col_entry.ero = ero;
      col_entry.dil = dil && s1_cxint_ff;
      col_entry.px  = lanes[cs[bed_pkg::SLOT_W-1:0]];
      pass_px       = lanes[s1_oslot_ff];
   end

   // Window shift line: entry 0 is the newest column, entry rx the centre.
   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         for (int i = 0; i < bed_pkg::MAX_WIN; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_push_ff) begin
         win_ff[0] <= col_entry;
         for (int i = 1; i < bed_pkg::MAX_WIN; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
      end else begin
         s2_emit_ff <= s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_last_ff  <= s1_last_ff;
      s2_pint_ff  <= s1_pint_ff;
      s2_noint_ff <= no_interior;
      s2_pass_ff  <= pass_px;
   end

   // Window reduction and choice of the result pixel.
   always_comb begin
      logic                      all_ero;
      logic                      any_dil;
      logic [bed_pkg::PIX_W-1:0] centre;
      all_ero = 1'b1;
      any_dil = 1'b0;
      for (int i = 0; i < bed_pkg::MAX_WIN; i++) begin
         if ((bed_pkg::REACH_W + 1)'(i) <= {rx, 1'b0}) begin
            all_ero = all_ero && win_ff[i].ero;
            any_dil = any_dil || win_ff[i].dil;
         end
      end
      centre = win_ff[bed_pkg::SLOT_W'(rx)].px;
      res_entry.last = s2_last_ff;
      if (s2_noint_ff) begin
         res_entry.px = s2_pass_ff;
      end else if (op_select_ff == bed_pkg::OP_ERODE) begin
         if (s2_pint_ff) begin
            res_entry.px = all_ero ? bed_pkg::PIX_ONES : bed_pkg::PIX_ZERO;
         end else begin
            res_entry.px = centre;
         end
      end else begin
         res_entry.px = any_dil ? bed_pkg::PIX_ONES : centre;
      end
   end

   // Result queue; the request side stops while results in flight could fill it.
   always_comb begin
      fifo_pop  = rsp_valid && rsp_ready;
      pending   = bed_pkg::FIFO_CNT_W'(s1_emit_ff) + bed_pkg::FIFO_CNT_W'(s2_emit_ff)
                + cnt_ff;
      req_ready = pending < bed_pkg::FIFO_CNT_W'(bed_pkg::FIFO_DEPTH);
      rsp_valid = cnt_ff != '0;
      rsp_out_pixel  = fifo_ff[rd_ptr_ff].px;
      rsp_frame_last = fifo_ff[rd_ptr_ff].last;
   end

   always_ff @(posedge clock) begin
      if (s2_emit_ff) begin
         fifo_ff[wr_ptr_ff] <= res_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (s2_emit_ff) begin
            wr_ptr_ff <= wr_ptr_ff + bed_pkg::FIFO_PTR_W'(1);
         end
         if (fifo_pop) begin
            rd_ptr_ff <= rd_ptr_ff + bed_pkg::FIFO_PTR_W'(1);
         end
         cnt_ff <= cnt_ff + bed_pkg::FIFO_CNT_W'(s2_emit_ff)
                          - bed_pkg::FIFO_CNT_W'(fifo_pop);
      end
   end

endmodule

`default_nettype wire

### hdl/bed_line_ram.sv
// Line store: one word per column, one byte lane per ring slot.
// Depends on bed_pkg; byte-lane write, registered read.
`default_nettype none

module bed_line_ram (
   input  wire logic                        clock,
   input  wire bed_pkg::ram_wr_type         wr,
   input  wire logic [bed_pkg::COL_W-1:0]   rd_addr,
   output bed_pkg::line_word_type           rd_data
);

   bed_pkg::line_word_type line_ram_ff [bed_pkg::MAX_WIDTH];
   bed_pkg::line_word_type rd_data_ff;

   // Write one lane of the addressed word.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         line_ram_ff[wr.addr][wr.lane] <= wr.data;
      end
   end

   // Read returns the word as it stood before this cycle's write.
   always_ff @(posedge clock) begin
      rd_data_ff <= line_ram_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### tb/sv/tb_binary_erosion_dilation.sv
// Self-checking testbench for binary_erosion_dilation: frames of pixels are streamed under
// many register settings, and every result beat is compared with a built-in predictor.
// Depends on bed_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_binary_erosion_dilation;

   localparam bit MODE_PIXEL = 1'b0;
   localparam bit MODE_DRAIN = 1'b1;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic [bed_pkg::PIX_W-1:0] px;
      logic                      last;
   } pixel_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_mode = 1'b0;
   logic [bed_pkg::PIX_W-1:0]      req_pixel = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [bed_pkg::PIX_W-1:0]      rsp_out_pixel;
   logic                           rsp_frame_last;
   logic                           csr_write_en = 1'b0;
   logic [bed_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bed_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   binary_erosion_dilation dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: line store, frame counters and register copies.
   logic [bed_pkg::PIX_W-1:0] line_mem [bed_pkg::MAX_WIN*bed_pkg::MAX_WIDTH];
   int unsigned      in_col_m, in_row_m, out_count_m;
   logic [10:0]      fw_m;
   logic [12:0]      fh_m;
   logic [3:0]       ww_m, wh_m;
   bed_pkg::op_type  op_m;
   bit               frame_flushed;

   pixel_result_type expected_pixels [$];
   int               error_count, items_sent, results_seen, frames_run;
   int               send_idle_pct, recv_idle_pct, hold_left;
   int               idle_cycles;

   // Beat samples taken at the falling edge, used at the next rising edge.
   logic                      seen_valid, seen_last, seen_req_beat;
   logic [bed_pkg::PIX_W-1:0] seen_px;

   function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int reach(logic [3:0] win);
      return (clampu(win, 1, bed_pkg::MAX_WIN) - 1) / 2;
   endfunction

   function automatic logic [bed_pkg::PIX_W-1:0] mem_at(int y, int x);
      return line_mem[(y % bed_pkg::MAX_WIN) * bed_pkg::MAX_WIDTH + (x % bed_pkg::MAX_WIDTH)];
   endfunction

   function automatic bit centre_ok(int y, int x, int w, int h, int rx, int ry);
      return x >= rx && x + rx <= w - 1 && y >= ry && y + ry <= h - 1;
   endfunction

   // Erosion or dilation of the pixel at raster position p.
   function automatic logic [bed_pkg::PIX_W-1:0] morph_pixel(int unsigned p, int w, int h,
                                                             int rx, int ry);
      int                        py, px;
      logic [bed_pkg::PIX_W-1:0] v;
      py = p / w;
      px = p % w;
      v = mem_at(py, px);
      if (op_m == bed_pkg::OP_ERODE) begin
         if (centre_ok(py, px, w, h, rx, ry)) begin
            v = bed_pkg::PIX_ONES;
            for (int dy = -ry; dy <= ry; dy++)
               for (int dx = -rx; dx <= rx; dx++)
                  if (mem_at(py + dy, px + dx) != bed_pkg::PIX_ONES) v = bed_pkg::PIX_ZERO;
         end
      end else begin
         for (int dy = -ry; dy <= ry; dy++)
            for (int dx = -rx; dx <= rx; dx++)
               if (centre_ok(py + dy, px + dx, w, h, rx, ry) &&
                   mem_at(py + dy, px + dx) == bed_pkg::PIX_ONES) v = bed_pkg::PIX_ONES;
      end
      return v;
   endfunction

   // Advances the predictor by one accepted request beat; queues any result.
   function automatic void predict_beat(bit mode, logic [bed_pkg::PIX_W-1:0] pixel);
      int unsigned      w, h, total, lag, recv;
      int               rx, ry;
      pixel_result_type r;
      w = clampu(fw_m, 1, bed_pkg::MAX_WIDTH);
      h = clampu(fh_m, 1, bed_pkg::MAX_HEIGHT);
      rx = reach(ww_m);
      ry = reach(wh_m);
      total = w * h;
      lag = ry * w + rx;
      recv = in_row_m * w + in_col_m;
      if (mode == MODE_PIXEL) begin
         if (recv >= total) return;
         line_mem[(in_row_m % bed_pkg::MAX_WIN) * bed_pkg::MAX_WIDTH + in_col_m] = pixel;
         in_col_m++;
         if (in_col_m >= w) begin
            in_col_m = 0;
            in_row_m++;
         end
         recv++;
         if (out_count_m + lag >= recv) return;
      end else begin
         if (recv != total || out_count_m >= total) return;
      end
      r.px = morph_pixel(out_count_m, w, h, rx, ry);
      r.last = (out_count_m == total - 1);
      expected_pixels.insert(expected_pixels.size(), r);
      out_count_m++;
      if (out_count_m >= total) begin
         in_col_m = 0;
         in_row_m = 0;
         out_count_m = 0;
         frame_flushed = 1;
      end
   endfunction

   task automatic report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Sends one request beat after a random gap and feeds it to the predictor.
   task automatic send_beat(bit mode, logic [bed_pkg::PIX_W-1:0] pixel);
      logic rdy;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_pixel <= pixel;
      do begin
         @(negedge clock);
         rdy = req_ready;
         @(posedge clock);
      end while (!rdy);
      predict_beat(mode, pixel);
   endtask

   // Waits until every expected result has come, then for the block's latency.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes all five registers while the block is idle.
   task automatic configure(int unsigned w, int unsigned h, int unsigned ww,
                            int unsigned wh, bed_pkg::op_type op);
      bed_pkg::csr_index_type idx;
      int unsigned            vals [5];
      vals = '{w, h, ww, wh, op};
      wait_drained();
      for (int i = 0; i < 5; i++) begin
         idx = bed_pkg::csr_index_type'(i);
         csr_write_en <= 1'b1;
         csr_index    <= idx;
         csr_wdata    <= vals[i][bed_pkg::CSR_DATA_W-1:0];
         @(posedge clock);
         case (idx)
            bed_pkg::CSR_FRAME_WIDTH:  fw_m = vals[i][10:0];
            bed_pkg::CSR_FRAME_HEIGHT: fh_m = vals[i][12:0];
            bed_pkg::CSR_WIN_WIDTH:    ww_m = vals[i][3:0];
            bed_pkg::CSR_WIN_HEIGHT:   wh_m = vals[i][3:0];
            default:                   op_m = bed_pkg::op_type'(vals[i][0]);
         endcase
         in_col_m = 0;
         in_row_m = 0;
         out_count_m = 0;
      end
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [bed_pkg::PIX_W-1:0] random_pixel(int density);
      if ($urandom_range(99) < 5) return bed_pkg::PIX_W'($urandom_range(255));
      return ($urandom_range(99) < density) ? bed_pkg::PIX_ONES : bed_pkg::PIX_ZERO;
   endfunction

   // One whole frame with stray beats mixed in; pause_at >= 0 halts the sender
   // at that pixel until every expected result has come.
   task automatic run_frame(int w, int h, int ww, int wh, bed_pkg::op_type op, int density,
                            int pause_at = -1);
      configure(w, h, ww, wh, op);
      frame_flushed = 0;
      frames_run++;
      for (int i = 0; i < w * h; i++) begin
         if (i == pause_at) wait_drained();
         if ($urandom_range(99) < 3)
            send_beat(MODE_DRAIN, bed_pkg::PIX_W'($urandom_range(255)));
         send_beat(MODE_PIXEL, random_pixel(density));
         items_sent++;
      end
      while (!frame_flushed) begin
         if ($urandom_range(99) < 8)
            send_beat(MODE_PIXEL, bed_pkg::PIX_W'($urandom_range(255)));
         send_beat(MODE_DRAIN, bed_pkg::PIX_W'($urandom_range(255)));
         items_sent++;
      end
      if ($urandom_range(99) < 20) send_beat(MODE_DRAIN, bed_pkg::PIX_W'($urandom_range(255)));
      wait_drained();
   endtask

   // Pixels under the reset setting: the window lag is longer than the beats sent.
   task automatic test_reset_setting();
      for (int i = 0; i < 4; i++) send_beat(MODE_PIXEL, random_pixel(50));
      wait_drained();
   endtask

   task automatic test_directed_frames();
      run_frame(1, 1, 1, 1, bed_pkg::OP_ERODE, 100);
      run_frame(4, 4, 3, 3, bed_pkg::OP_ERODE, 100);
      run_frame(4, 4, 3, 3, bed_pkg::OP_DILATE, 20);
      run_frame(5, 3, 4, 2, bed_pkg::OP_ERODE, 90);
      run_frame(3, 3, 9, 9, bed_pkg::OP_DILATE, 50);
      run_frame(3, 2, 0, 15, bed_pkg::OP_ERODE, 100);
   endtask

   // Out-of-range sizes saturate; frames are left partial where they are huge.
   task automatic test_saturation();
      configure(2047, 1, 1, 1, bed_pkg::OP_ERODE);
      for (int i = 0; i < 12; i++) send_beat(MODE_PIXEL, random_pixel(50));
      configure(0, 0, 1, 1, bed_pkg::OP_DILATE);
      for (int i = 0; i < 3; i++) send_beat(MODE_PIXEL, random_pixel(50));
      configure(1, 8191, 1, 1, bed_pkg::OP_ERODE);
      for (int i = 0; i < 10; i++) send_beat(MODE_PIXEL, random_pixel(50));
      configure(1024, 4096, 9, 9, bed_pkg::OP_DILATE);
      for (int i = 0; i < 10; i++) send_beat(MODE_PIXEL, random_pixel(50));
      wait_drained();
   endtask

   // Long receiver hold-off so the block fills up, then a sender pause mid-frame.
   task automatic test_pressure();
      hold_left = 400;
      run_frame(10, 8, 3, 3, bed_pkg::OP_ERODE, 90);
      run_frame(6, 6, 3, 3, bed_pkg::OP_DILATE, 30, 18);
   endtask

   task automatic test_random_frames(int target, int s_pct, int r_pct);
      int w, h, ww, wh;
      target += items_sent;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      while (items_sent < target) begin
         if ($urandom_range(99) < 90) begin
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 12);
         end else begin
            w = $urandom_range(17, 48);
            h = $urandom_range(1, 20);
         end
         ww = ($urandom_range(99) < 85) ? $urandom_range(1, 9) : $urandom_range(0, 15);
         wh = ($urandom_range(99) < 85) ? $urandom_range(1, 9) : $urandom_range(0, 15);
         run_frame(w, h, ww, wh, bed_pkg::op_type'($urandom_range(1)),
                   $urandom_range(0, 100));
      end
   endtask

   // Result side: random stalls, hold-off, and comparison against the oldest expectation.
   always @(negedge clock) begin
      seen_valid    = rsp_valid;
      seen_px       = rsp_out_pixel;
      seen_last     = rsp_frame_last;
      seen_req_beat = req_valid && req_ready;
   end

   always @(posedge clock) begin
      pixel_result_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (seen_valid && rsp_ready) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
               report($sformatf("unexpected result px=%0d last=%0b", seen_px, seen_last));
            end else begin
               e = expected_pixels.pop_front();
               if (seen_px !== e.px)
                  report($sformatf("out_pixel %0d, expected %0d", seen_px, e.px));
               if (seen_last !== e.last)
                  report($sformatf("frame_last %0b, expected %0b", seen_last, e.last));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (seen_req_beat || (seen_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat for %0d cycles", STALL_LIMIT);
         $display("tb_binary_erosion_dilation: FAIL");
         $finish;
      end
   end

   initial begin
      fw_m = 11'd1024;
      fh_m = 13'd1024;
      ww_m = 4'd3;
      wh_m = 4'd3;
      op_m = bed_pkg::OP_ERODE;
      send_idle_pct = 9;
      recv_idle_pct = 80;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_setting();
      test_directed_frames();
      test_saturation();
      test_pressure();
      test_random_frames(400, 9, 80);
      test_random_frames(400, 80, 9);
      test_random_frames(400, 0, 0);
      wait_drained();

      $display("covered %0d frames and %0d counted beats, %0d results checked,",
               frames_run, items_sent, results_seen);
      $display("both operations, saturated sizes, stray beats, hold-off and pause");
      if (error_count == 0) begin
         $display("tb_binary_erosion_dilation: PASS");
      end else begin
         $display("%0d mismatches", error_count);
         $display("tb_binary_erosion_dilation: FAIL");
      end
      $finish;
   end

endmodule
